>>> hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> hw/rtl/ped_pkg.sv
`timescale 1ns / 1ps
package ped_pkg;
  localparam int MaxNodes = 16;
  localparam int MaxAttrs = 8;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int AttrW = (MaxAttrs > 1) ? $clog2(MaxAttrs) : 1;
  localparam int StoreDepth = MaxNodes * MaxAttrs;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int SumW = 40;
  localparam int RadW = 56;
  localparam int RootW = 28;
  localparam int TotW = 40;
  localparam logic [25:0] DistMax = 26'h3FFFFFF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_DIST  = 2'd1,
    ACT_MEAN  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2
  } status_t;

  typedef struct packed {
    logic        is_write;
    logic        is_mean;
    logic        direct;
    logic [1:0]  status;
    logic [NodeW-1:0] n1;
    logic [NodeW-1:0] n2;
    logic [AttrW-1:0] ai;
    logic [15:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_ACC, BK_SQRT, BK_DIV, BK_OUT
  } bk_state_t;
endpackage

>>> hw/rtl/ped_if.sv
`timescale 1ns / 1ps
interface ped_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  first_node;
  logic [3:0]  second_node;
  logic [2:0]  attribute_index;
  logic signed [15:0] attribute_value;
  modport source (output valid, action, first_node, second_node, attribute_index,
                  attribute_value, input ready);
  modport sink (input valid, action, first_node, second_node, attribute_index,
                attribute_value, output ready);
endinterface

interface ped_out_if;
  logic        valid;
  logic        ready;
  logic [25:0] distance;
  logic [1:0]  status;
  modport source (output valid, distance, status, input ready);
  modport sink (input valid, distance, status, output ready);
endinterface

>>> hw/rtl/ped_front.sv
`timescale 1ns / 1ps
module ped_front (
  input  logic clk,
  input  logic rst_n,
  ped_in_if.sink in_ch,
  input  logic [4:0] nodes_eff,
  output logic q_valid,
  input  logic q_ready,
  output ped_pkg::cmd_t q_cmd
);
  import ped_pkg::*;

  cmd_t c;
  logic [1:0] fifo_cnt_r, fifo_cnt_nxt;
  cmd_t fifo_r [2];
  logic wp_r, rp_r;
  logic push, pop;

  always_comb begin
    c = '0;
    c.n1 = in_ch.first_node[NodeW-1:0];
    c.n2 = in_ch.second_node[NodeW-1:0];
    c.ai = in_ch.attribute_index[AttrW-1:0];
    c.value = in_ch.attribute_value;
    c.direct = 1'b1;
    c.status = ST_OK;
    case (action_t'(in_ch.action))
      ACT_WRITE: begin
        if ({1'b0, in_ch.attribute_index} >= 4'(MaxAttrs)) c.status = ST_RANGE;
        else c.is_write = 1'b1;
      end
      ACT_DIST: begin
        if ({1'b0, in_ch.first_node} >= nodes_eff ||
            {1'b0, in_ch.second_node} >= nodes_eff) c.status = ST_RANGE;
        else if (in_ch.first_node != in_ch.second_node) c.direct = 1'b0;
      end
      ACT_MEAN: begin
        if (nodes_eff < 5'd2) c.status = ST_FEW;
        else begin
          c.direct = 1'b0;
          c.is_mean = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (fifo_cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (fifo_cnt_r != 2'd0);
  assign q_cmd = fifo_r[rp_r];
  assign fifo_cnt_nxt = fifo_cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= c;
  end
endmodule

>>> hw/rtl/ped_back.sv
`timescale 1ns / 1ps
module ped_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  ped_pkg::cmd_t q_cmd,
  input  logic [4:0] nodes_eff,
  input  logic [3:0] attrs_eff,
  output logic clr_busy,
  ped_out_if.source out_ch
);
  import ped_pkg::*;

  // store, cleared by a sweep after reset
  logic [15:0] mem [StoreDepth];
  logic [15:0] rd_r;
  logic [AddrW:0] clr_r;
  assign clr_busy = !clr_r[AddrW];

  bk_state_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [NodeW-1:0] i_r, j_r;
  logic [AttrW:0] k_r;
  logic phase_r, pend_r;
  logic signed [15:0] a_r;
  logic [SumW-1:0] sum_r;
  logic [RadW-1:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [4:0] sq_cnt_r;
  logic [TotW-1:0] tot_r, quo_r, drem_r;
  logic [7:0] pairs_r;
  logic [5:0] dv_cnt_r;
  logic [25:0] od_r;
  logic [1:0] os_r;
  logic ov_r;

  logic [AddrW-1:0] raddr;
  logic [NodeW-1:0] rnode;
  logic signed [16:0] diff;
  logic [15:0] mag;
  logic [31:0] sq;
  logic [RadW-1:0] radicand, trial;
  logic [RadW+1:0] rem_sh;
  logic root_bit;
  logic [RootW-1:0] root_new;
  logic [25:0] dsat;
  logic [TotW:0] dv_sh;
  logic last_attr, last_pair;

  assign rnode = phase_r ? j_r : i_r;
  assign raddr = AddrW'({rnode, k_r[AttrW-1:0]});
  assign diff = 17'(a_r) - 17'($signed(rd_r));
  assign mag = diff[16] ? 16'(-diff) : diff[15:0];
  assign sq = mag * mag;
  assign radicand = RadW'(sum_r) << 16;
  assign rem_sh = {rem_r, radicand[RadW-1 -: 2]};
  assign trial = RadW'({root_r, 2'b01});
  assign root_bit = (rem_sh >= {2'b0, trial});
  assign root_new = {root_r[RootW-2:0], root_bit};
  assign dsat = (|root_new[RootW-1:26]) ? DistMax : root_new[25:0];
  assign dv_sh = {drem_r, quo_r[TotW-1]};
  assign last_attr = (k_r == (AttrW+1)'(attrs_eff));
  assign last_pair = !cmd_r.is_mean ||
      ((5'(j_r) == nodes_eff - 5'd1) && (5'(i_r) == nodes_eff - 5'd2));

  assign q_ready = (st_r == BK_IDLE) && !clr_busy && (!ov_r || out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.distance = od_r;
  assign out_ch.status = os_r;

  always_ff @(posedge clk) begin
    if (clr_busy) mem[clr_r[AddrW-1:0]] <= '0;
    else if (q_valid && q_ready && q_cmd.is_write)
      mem[AddrW'({q_cmd.n1, q_cmd.ai})] <= q_cmd.value;
    rd_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid && q_ready && !q_cmd.direct) st_nxt = BK_ACC;
      BK_ACC:  if (attrs_eff == 4'd0 || (pend_r && !phase_r && last_attr)) st_nxt = BK_SQRT;
      BK_SQRT: if (sq_cnt_r == 5'd0) st_nxt = last_pair ?
                 (cmd_r.is_mean ? BK_DIV : BK_OUT) : BK_ACC;
      BK_DIV:  if (dv_cnt_r == 6'd0) st_nxt = BK_OUT;
      BK_OUT:  if (!ov_r || out_ch.ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clr_busy) clr_r <= clr_r + 1'b1;
      if ((st_r == BK_IDLE && q_valid && q_ready && q_cmd.direct) ||
          (st_r == BK_OUT && (!ov_r || out_ch.ready))) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: if (q_valid && q_ready) begin
        cmd_r <= q_cmd;
        od_r <= '0;
        os_r <= q_cmd.status;
        i_r <= q_cmd.is_mean ? '0 : q_cmd.n1;
        j_r <= q_cmd.is_mean ? NodeW'(1) : q_cmd.n2;
        k_r <= '0; phase_r <= 1'b0; pend_r <= 1'b0;
        sum_r <= '0; tot_r <= '0;
        pairs_r <= 8'(({3'b0, nodes_eff} * ({3'b0, nodes_eff} - 8'd1)) >> 1);
      end
      BK_ACC: begin
        // phase 0 reads node a, phase 1 reads node b; the read data is registered in rd_r
        pend_r <= 1'b1;
        if (pend_r && phase_r) a_r <= $signed(rd_r);
        if (pend_r && !phase_r) sum_r <= sum_r + SumW'(sq);
        phase_r <= ~phase_r;
        if (phase_r) k_r <= k_r + 1'b1;
        rem_r <= '0; root_r <= '0; sq_cnt_r <= 5'd27;
      end
      BK_SQRT: begin
        if (root_bit) rem_r <= RadW'(rem_sh - {2'b0, trial});
        else rem_r <= RadW'(rem_sh);
        root_r <= root_new;
        sq_cnt_r <= sq_cnt_r - 1'b1;
        if (sq_cnt_r == 5'd0) begin
          if (!cmd_r.is_mean) od_r <= dsat;
          tot_r <= tot_r + TotW'(dsat);
          quo_r <= tot_r + TotW'(dsat);
          drem_r <= '0; dv_cnt_r <= 6'(TotW - 1);
          k_r <= '0; phase_r <= 1'b0; pend_r <= 1'b0; sum_r <= '0;
          if (5'(j_r) == nodes_eff - 5'd1) begin
            i_r <= i_r + 1'b1; j_r <= i_r + NodeW'(2);
          end else j_r <= j_r + 1'b1;
        end else begin
          sum_r <= sum_r << 2;
        end
      end
      BK_DIV: begin
        if (dv_sh >= (TotW+1)'(pairs_r)) begin
          drem_r <= TotW'(dv_sh - (TotW+1)'(pairs_r));
          quo_r <= {quo_r[TotW-2:0], 1'b1};
        end else begin
          drem_r <= TotW'(dv_sh);
          quo_r <= {quo_r[TotW-2:0], 1'b0};
        end
        dv_cnt_r <= dv_cnt_r - 1'b1;
      end
      BK_OUT: if (cmd_r.is_mean && (!ov_r || out_ch.ready)) od_r <= quo_r[25:0];
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/pairwise_euclidean_distance_core.sv
// Writes and flagged items are answered directly; a distance sums A attributes.
// Mean averages the distances of P = n(n-1)/2 pairs; one item in the back end at a time.
// Items use the shared accumulate and 28-step root; mean adds a 40-step divide.
// rst_n is synchronous; after reset a sweep clears the point store's 128 entries,
// during which the back end takes no item. Registers reset to 16 nodes and 8 attributes.
`timescale 1ns / 1ps
module pairwise_euclidean_distance_core (
  input  logic clk,
  input  logic rst_n,
  ped_in_if.sink in_ch,
  ped_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [4:0] cfg_wdata
);
  import ped_pkg::*;

  logic [4:0] nodes_r;
  logic [3:0] attrs_r;
  logic [4:0] nodes_eff;
  logic [3:0] attrs_eff;
  logic q_valid, q_ready, clr_busy;
  cmd_t q_cmd;

  assign nodes_eff = (nodes_r > 5'(MaxNodes)) ? 5'(MaxNodes) : nodes_r;
  assign attrs_eff = (attrs_r > 4'(MaxAttrs)) ? 4'(MaxAttrs) : attrs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= 5'd16;
      attrs_r <= 4'd8;
    end else if (cfg_we) begin
      if (!cfg_index) nodes_r <= cfg_wdata;
      else attrs_r <= cfg_wdata[3:0];
    end
  end

  ped_front u_front (.clk, .rst_n, .in_ch, .nodes_eff, .q_valid, .q_ready, .q_cmd);
  ped_back u_back (.clk, .rst_n, .q_valid, .q_ready, .q_cmd, .nodes_eff, .attrs_eff,
                   .clr_busy, .out_ch);
endmodule

>>> hw/rtl/ped_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ped_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [25:0] out_distance,
  input logic [1:0] out_status
);
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_status != 2'd0, out_distance == 26'd0, "error with distance")
  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status != 2'd3, "bad status")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_distance), "beat dropped")
endmodule

bind pairwise_euclidean_distance_core ped_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_distance(out_ch.distance), .out_status(out_ch.status));
